// ===== sv/tlshs_pkg.sv =====
`timescale 1ns / 1ps
package tlshs_pkg;

    localparam int MAX_SEGMENT_BYTES_DEF = 65535;
    localparam int TDATA_W = 80;

    localparam logic [7:0]  REC_HANDSHAKE  = 8'h16;
    localparam logic [7:0]  HS_CLIENT      = 8'h01;
    localparam logic [7:0]  HS_SERVER      = 8'h02;
    localparam logic [7:0]  REC_MAJOR      = 8'h03;
    localparam logic [15:0] EXT_VERSIONS   = 16'h002b;
    localparam logic [15:0] EXT_SNI        = 16'h0000;
    localparam logic [15:0] VER_TLS13      = 16'h0304;
    localparam logic [7:0]  NAME_TYPE_HOST = 8'h00;
    localparam logic [24:0] SERVER_MIN_LEN = 25'd38;
    localparam logic [16:0] FIXED_END      = 17'd43;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TLS    = 2'd1;
    localparam logic [1:0] KIND_CLIENT = 2'd2;
    localparam logic [1:0] KIND_SERVER = 2'd3;

    typedef enum logic [4:0] {
        PH_REC_TYPE, PH_REC_VER, PH_REC_MINOR, PH_REC_LEN_HI, PH_REC_LEN_LO,
        PH_HS_TYPE, PH_HS_LEN1, PH_HS_LEN2, PH_HS_LEN3, PH_SKIP,
        PH_SESSION_LEN, PH_SUITES_HI, PH_SUITES_LO, PH_COMP_LEN,
        PH_EXTS_HI, PH_EXTS_LO, PH_EXT_T0, PH_EXT_T1, PH_EXT_L0, PH_EXT_L1,
        PH_SV_LEN, PH_SV_HI, PH_SV_LO,
        PH_SN_LIST_HI, PH_SN_LIST_LO, PH_SN_TYPE, PH_SN_LEN_HI, PH_SN_LEN_LO,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [15:0] sni_length;
        logic [15:0] sni_offset;
        logic        sni_valid;
        logic        tls13_seen;
        logic        extensions_truncated;
        logic [15:0] mid_off;
        logic        mid_ok;
        logic [15:0] rec_end_off;
        logic        rec_end_ok;
        logic [7:0]  rec_type_byte;
        logic [1:0]  message_kind;
    } result_t;

endpackage

// ===== sv/tls_hello_sni_parser.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata                 | tuser | tlast
// s_      | in  | data_byte[7:0]        | -     | last_byte
// m_      | out | result fields, 80 bit | -     | -
//
// one byte per cycle while s_tready is high; a segment's result is registered the
// cycle after its last byte and the parse state clears on that same edge
// throughput is one transaction per clock while s_tready is high
// s_tready drops only while a result is held and m_tready is low
// aresetn is synchronous and clears the parse state and the result register
module tls_hello_sni_parser #(
    parameter int MAX_SEGMENT_BYTES = tlshs_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // message_kind, rec_type_byte, rec_end_ok, rec_end_off, mid_ok,
    // mid_off, extensions_truncated, tls13_seen, sni_valid, sni_offset,
    // sni_length, zero pad
    output logic [tlshs_pkg::TDATA_W-1:0] m_tdata
);
    import tlshs_pkg::*;

    logic    in_fire;
    result_t result;
    logic    m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    tlshs_parse #(.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (in_fire),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (in_fire && s_tlast) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = TDATA_W'(result);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/tlshs_parse.sv =====
`timescale 1ns / 1ps
module tlshs_parse #(
    parameter int MAX_SEGMENT_BYTES = tlshs_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output tlshs_pkg::result_t  result
);
    import tlshs_pkg::*;

    localparam logic [15:0] POS_MAX = 16'(MAX_SEGMENT_BYTES);

    logic [15:0] pos_reg, pos_next;
    phase_t      phase_reg, phase_next, resume_reg, resume_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  type_reg, type_next, hello_reg, hello_next;
    logic [16:0] claimed_reg, claimed_next, hs_end_reg, hs_end_next;
    logic [23:0] acc_reg, acc_next;
    logic [16:0] field_end_reg, field_end_next, blk_end_reg, blk_end_next;
    logic [16:0] ext_end_reg, ext_end_next, lst_end_reg, lst_end_next;
    logic [16:0] sni_ext_end_reg, sni_ext_end_next;
    logic [15:0] ext_kind_reg, ext_kind_next, fnd_off_reg, fnd_off_next;
    logic [15:0] fnd_len_reg, fnd_len_next;
    logic        ver_found_reg, ver_found_next, ver_done_reg, ver_done_next;
    logic        sni_done_reg, sni_done_next, block_reg, block_next;
    logic        sni_found_reg, sni_found_next;

    logic [17:0] here, fend, bound, ext_n;
    logic [24:0] hs_full;
    logic [23:0] acc_sn;
    logic [16:0] avail, hs_eff;
    logic        have_rec, have_mid, trunc, sni_ok;

    always_comb begin
        pos_next = pos_reg; phase_next = phase_reg; resume_next = resume_reg;
        kind_next = kind_reg; type_next = type_reg; hello_next = hello_reg;
        claimed_next = claimed_reg; hs_end_next = hs_end_reg; acc_next = acc_reg;
        field_end_next = field_end_reg; blk_end_next = blk_end_reg;
        ext_end_next = ext_end_reg; lst_end_next = lst_end_reg;
        sni_ext_end_next = sni_ext_end_reg; ext_kind_next = ext_kind_reg;
        fnd_off_next = fnd_off_reg; fnd_len_next = fnd_len_reg;
        ver_found_next = ver_found_reg; ver_done_next = ver_done_reg;
        sni_done_next = sni_done_reg; block_next = block_reg;
        sni_found_next = sni_found_reg;
        here    = 18'(pos_reg) + 18'd1;
        fend    = '0;
        ext_n   = 18'({acc_reg[7:0], data_byte});
        hs_full = 25'd9 + 25'({acc_reg[15:0], data_byte});
        acc_sn  = {acc_reg[15:0], data_byte};
        bound   = (blk_end_reg < hs_end_reg) ? 18'(blk_end_reg) : 18'(hs_end_reg);
        if (byte_en && pos_reg < POS_MAX) begin
            pos_next = pos_reg + 16'd1;
            case (phase_reg)
                PH_REC_TYPE: begin
                    type_next = data_byte; phase_next = PH_REC_VER;
                end
                PH_REC_VER: phase_next = (data_byte == REC_MAJOR) ? PH_REC_MINOR : PH_DONE;
                PH_REC_MINOR: begin
                    kind_next = KIND_TLS; phase_next = PH_REC_LEN_HI;
                end
                PH_REC_LEN_HI: begin
                    acc_next = 24'(data_byte); phase_next = PH_REC_LEN_LO;
                end
                PH_REC_LEN_LO: begin
                    claimed_next = 17'd5 + 17'({acc_reg[7:0], data_byte});
                    phase_next = (type_reg != REC_HANDSHAKE || claimed_next < 17'd9) ?
                                 PH_DONE : PH_HS_TYPE;
                end
                PH_HS_TYPE: begin
                    hello_next = data_byte;
                    phase_next = (data_byte == HS_CLIENT || data_byte == HS_SERVER) ?
                                 PH_HS_LEN1 : PH_DONE;
                end
                PH_HS_LEN1: begin
                    acc_next = 24'(data_byte); phase_next = PH_HS_LEN2;
                end
                PH_HS_LEN2: begin
                    acc_next = {acc_reg[15:0], data_byte}; phase_next = PH_HS_LEN3;
                end
                PH_HS_LEN3: begin
                    phase_next = PH_DONE;
                    if (hello_reg == HS_SERVER) begin
                        if (hs_full >= SERVER_MIN_LEN + 25'd9 && hs_full <= 25'(claimed_reg))
                            kind_next = KIND_SERVER;
                    end else if (hs_full <= 25'(claimed_reg)) begin
                        kind_next = KIND_CLIENT;
                        hs_end_next = hs_full[16:0];
                        if (hs_full[16:0] >= FIXED_END) begin
                            field_end_next = FIXED_END;
                            resume_next = PH_SESSION_LEN;
                            phase_next = (18'(FIXED_END) <= here) ? PH_SESSION_LEN : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: if (here >= 18'(field_end_reg)) phase_next = resume_reg;
                PH_SESSION_LEN, PH_COMP_LEN: begin
                    fend = here + 18'(data_byte);
                    resume_next = (phase_reg == PH_SESSION_LEN) ? PH_SUITES_HI : PH_EXTS_HI;
                    if (here > 18'(hs_end_reg) || fend > 18'(hs_end_reg)) begin
                        phase_next = PH_DONE;
                    end else begin
                        field_end_next = fend[16:0];
                        phase_next = (fend <= here) ? resume_next : PH_SKIP;
                    end
                end
                PH_SUITES_HI, PH_EXTS_HI: begin
                    if (here + 18'd1 > 18'(hs_end_reg)) begin
                        phase_next = PH_DONE;
                    end else begin
                        acc_next = 24'(data_byte);
                        phase_next = (phase_reg == PH_SUITES_HI) ? PH_SUITES_LO : PH_EXTS_LO;
                    end
                end
                PH_SUITES_LO: begin
                    fend = here + ext_n;
                    resume_next = PH_COMP_LEN;
                    if (fend > 18'(hs_end_reg)) begin
                        phase_next = PH_DONE;
                    end else begin
                        field_end_next = fend[16:0];
                        phase_next = (fend <= here) ? PH_COMP_LEN : PH_SKIP;
                    end
                end
                PH_EXTS_LO: begin
                    fend = here + ext_n;
                    if (fend > 18'(claimed_reg)) begin
                        phase_next = PH_DONE;
                    end else begin
                        blk_end_next = fend[16:0];
                        block_next = 1'b1;
                        phase_next = PH_EXT_T0;
                    end
                end
                PH_EXT_T0: begin
                    if (here + 18'd3 > bound) begin
                        phase_next = PH_DONE;
                    end else begin
                        acc_next = 24'(data_byte); phase_next = PH_EXT_T1;
                    end
                end
                PH_EXT_T1: begin
                    ext_kind_next = {acc_reg[7:0], data_byte}; phase_next = PH_EXT_L0;
                end
                PH_EXT_L0: begin
                    acc_next = 24'(data_byte); phase_next = PH_EXT_L1;
                end
                PH_EXT_L1: begin
                    fend = here + ext_n;
                    if (fend > bound) begin
                        phase_next = PH_DONE;
                    end else begin
                        ext_end_next = fend[16:0];
                        field_end_next = fend[16:0];
                        resume_next = PH_EXT_T0;
                        phase_next = (fend <= here) ? PH_EXT_T0 : PH_SKIP;
                        if (ext_kind_reg == EXT_VERSIONS && !ver_done_reg) begin
                            ver_done_next = 1'b1;
                            if (ext_n >= 18'd1) phase_next = PH_SV_LEN;
                        end else if (ext_kind_reg == EXT_SNI && !sni_done_reg) begin
                            sni_done_next = 1'b1;
                            if (ext_n >= 18'd2) phase_next = PH_SN_LIST_HI;
                        end
                    end
                end
                PH_SV_LEN: begin
                    fend = here + 18'(data_byte);
                    if (fend <= 18'(ext_end_reg) && here + 18'd2 <= fend) begin
                        lst_end_next = fend[16:0];
                        phase_next = PH_SV_HI;
                    end else begin
                        field_end_next = ext_end_reg; resume_next = PH_EXT_T0;
                        phase_next = (18'(ext_end_reg) <= here) ? PH_EXT_T0 : PH_SKIP;
                    end
                end
                PH_SV_HI: begin
                    acc_next = 24'(data_byte); phase_next = PH_SV_LO;
                end
                PH_SV_LO: begin
                    if ({acc_reg[7:0], data_byte} != VER_TLS13 &&
                        here + 18'd2 <= 18'(lst_end_reg)) begin
                        phase_next = PH_SV_HI;
                    end else begin
                        if ({acc_reg[7:0], data_byte} == VER_TLS13) ver_found_next = 1'b1;
                        field_end_next = ext_end_reg; resume_next = PH_EXT_T0;
                        phase_next = (18'(ext_end_reg) <= here) ? PH_EXT_T0 : PH_SKIP;
                    end
                end
                PH_SN_LIST_HI: begin
                    acc_next = 24'(data_byte); phase_next = PH_SN_LIST_LO;
                end
                PH_SN_LIST_LO: begin
                    fend = here + ext_n;
                    if (fend <= 18'(ext_end_reg) && here + 18'd3 <= fend) begin
                        lst_end_next = fend[16:0];
                        phase_next = PH_SN_TYPE;
                    end else begin
                        field_end_next = ext_end_reg; resume_next = PH_EXT_T0;
                        phase_next = (18'(ext_end_reg) <= here) ? PH_EXT_T0 : PH_SKIP;
                    end
                end
                PH_SN_TYPE: begin
                    acc_next = 24'(data_byte); phase_next = PH_SN_LEN_HI;
                end
                PH_SN_LEN_HI: begin
                    acc_next = {acc_reg[15:0], data_byte}; phase_next = PH_SN_LEN_LO;
                end
                PH_SN_LEN_LO: begin
                    acc_next = acc_sn;
                    fend = here + 18'(acc_sn[15:0]);
                    field_end_next = ext_end_reg; resume_next = PH_EXT_T0;
                    phase_next = (18'(ext_end_reg) <= here) ? PH_EXT_T0 : PH_SKIP;
                    if (fend <= 18'(lst_end_reg)) begin
                        if (acc_sn[23:16] == NAME_TYPE_HOST) begin
                            if (acc_sn[15:0] != 16'd0) begin
                                sni_found_next = 1'b1;
                                fnd_off_next = here[15:0];
                                fnd_len_next = acc_sn[15:0];
                                sni_ext_end_next = ext_end_reg;
                            end
                        end else if (fend + 18'd3 <= 18'(lst_end_reg)) begin
                            field_end_next = fend[16:0]; resume_next = PH_SN_TYPE;
                            phase_next = (fend <= here) ? PH_SN_TYPE : PH_SKIP;
                        end
                    end
                end
                default: phase_next = PH_DONE;
            endcase
        end
    end

    // segment summary from the state after this byte
    always_comb begin
        avail    = 17'(pos_next);
        have_rec = kind_next != KIND_NONE && claimed_next != '0 && claimed_next <= avail;
        have_mid = kind_next == KIND_CLIENT && hs_end_next <= avail;
        hs_eff   = (hs_end_next < avail) ? hs_end_next : avail;
        trunc    = block_next && blk_end_next > hs_eff;
        sni_ok   = sni_found_next && sni_ext_end_next <= avail;
        result.message_kind         = kind_next;
        result.rec_type_byte        = (kind_next != KIND_NONE) ? type_next : 8'd0;
        result.rec_end_ok           = have_rec;
        result.rec_end_off          = have_rec ? claimed_next[15:0] : 16'd0;
        result.mid_ok               = have_mid;
        result.mid_off              = have_mid ?
            16'(17'd9 + ((hs_end_next - 17'd9) >> 1)) : 16'd0;
        result.extensions_truncated = trunc;
        result.tls13_seen           = block_next && !trunc && ver_found_next;
        result.sni_valid            = sni_ok;
        result.sni_offset           = sni_ok ? fnd_off_next : 16'd0;
        result.sni_length           = sni_ok ? fnd_len_next : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_en && last_byte)) begin
            pos_reg <= '0; phase_reg <= PH_REC_TYPE; resume_reg <= PH_REC_TYPE;
            kind_reg <= '0; type_reg <= '0; hello_reg <= '0; claimed_reg <= '0;
            hs_end_reg <= '0; acc_reg <= '0; field_end_reg <= '0; blk_end_reg <= '0;
            ext_end_reg <= '0; lst_end_reg <= '0; sni_ext_end_reg <= '0;
            ext_kind_reg <= '0; fnd_off_reg <= '0; fnd_len_reg <= '0;
            ver_found_reg <= 1'b0; ver_done_reg <= 1'b0; sni_done_reg <= 1'b0;
            block_reg <= 1'b0; sni_found_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next; phase_reg <= phase_next; resume_reg <= resume_next;
            kind_reg <= kind_next; type_reg <= type_next; hello_reg <= hello_next;
            claimed_reg <= claimed_next; hs_end_reg <= hs_end_next; acc_reg <= acc_next;
            field_end_reg <= field_end_next; blk_end_reg <= blk_end_next;
            ext_end_reg <= ext_end_next; lst_end_reg <= lst_end_next;
            sni_ext_end_reg <= sni_ext_end_next; ext_kind_reg <= ext_kind_next;
            fnd_off_reg <= fnd_off_next; fnd_len_reg <= fnd_len_next;
            ver_found_reg <= ver_found_next; ver_done_reg <= ver_done_next;
            sni_done_reg <= sni_done_next; block_reg <= block_next;
            sni_found_reg <= sni_found_next;
        end
    end

endmodule

// ===== sv/tlshs_checker.sv =====
`timescale 1ns / 1ps
module tlshs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // input stalls only behind a pending result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without backpressure");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[9:2] == 8'd0 && !m_tdata[10])
        else $error("non tls result carries record fields");

    a_sni: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[46] |-> m_tdata[78:47] == 32'd0)
        else $error("sni fields without sni");
endmodule

bind tls_hello_sni_parser tlshs_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
